// ===== rtl/core/ihex_pkg.sv =====
// Package for the hex record parser: phase codes, character constants, state and result types.
`timescale 1ns / 1ps

package ihex_pkg;

  localparam logic [7:0] COLON_CHAR = 8'h3A;
  localparam logic [7:0] DIGIT_BELOW = 8'd47;
  localparam logic [7:0] DIGIT_ABOVE = 8'd58;
  localparam logic [7:0] ZERO_CHAR = 8'd48;
  localparam logic [7:0] ALPHA_CHAR = 8'd65;
  localparam logic [7:0] ALPHA_OFFSET = 8'd10;

  typedef enum logic [5:0] {
    PH_WAIT = 6'b000001,
    PH_LEN  = 6'b000010,
    PH_ADDR = 6'b000100,
    PH_TYPE = 6'b001000,
    PH_DATA = 6'b010000,
    PH_SUM  = 6'b100000
  } phase_e;

  typedef struct packed {
    phase_e       phase;
    logic [1:0]   digit;
    logic [7:0]   length;
    logic [15:0]  address;
    logic [7:0]   index;
    logic [3:0]   high;
    logic [31:0]  total;
    logic [15:0]  max_addr;
  } ihex_state_t;

  typedef struct packed {
    logic [15:0]  byte_address;
    logic [7:0]   byte_value;
    logic [31:0]  bytes_so_far;
    logic [15:0]  highest_address;
  } ihex_result_t;

  // Digit code as decoded by the original tool: non-digits map as letters, no check.
  function automatic logic [7:0] nib_code(input logic [7:0] c);
    logic [7:0] r;
    if (c > DIGIT_BELOW && c < DIGIT_ABOVE) begin
      r = c - ZERO_CHAR;
    end else begin
      r = c - ALPHA_CHAR + ALPHA_OFFSET;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/ihex_if.sv =====
// Valid/ready channel interfaces for text characters in and decoded bytes out.
`timescale 1ns / 1ps

interface ihex_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  modport source (output valid, output text_char, input ready);
  modport sink (input valid, input text_char, output ready);
endinterface

interface ihex_byte_if;
  logic        valid;
  logic        ready;
  logic [15:0] byte_address;
  logic [7:0]  byte_value;
  logic [31:0] bytes_so_far;
  logic [15:0] highest_address;
  modport source (output valid, output byte_address, output byte_value,
                  output bytes_so_far, output highest_address, input ready);
  modport sink (input valid, input byte_address, input byte_value,
                input bytes_so_far, input highest_address, output ready);
endinterface

// ===== rtl/core/ihex_step.sv =====
// Next-state and result logic for one character of record text.
`timescale 1ns / 1ps

module ihex_step (
  input  ihex_pkg::ihex_state_t  state_i,
  input  logic [7:0]             text_char_i,
  output ihex_pkg::ihex_state_t  state_o,
  output ihex_pkg::ihex_result_t result_o,
  output logic                   result_valid_o
);
  import ihex_pkg::*;

  logic [7:0]  v;
  logic [15:0] byte_addr;
  logic [7:0]  next_index;

  assign v = nib_code(text_char_i);
  assign byte_addr = state_i.address + {8'h00, state_i.index};
  assign next_index = state_i.index + 8'd1;

  always_comb begin
    state_o = state_i;
    result_o = '0;
    result_valid_o = 1'b0;
    unique case (state_i.phase)
      PH_LEN: begin
        if (state_i.digit == 2'd0) begin
          state_o.high = v[3:0];
          state_o.digit = 2'd1;
        end else begin
          state_o.length = {state_i.high, 4'h0} + v;
          state_o.digit = 2'd0;
          state_o.phase = PH_ADDR;
        end
      end
      PH_ADDR: begin
        case (state_i.digit)
          2'd0: state_o.address = state_i.address | {v[3:0], 12'h000};
          2'd1: state_o.address = state_i.address | {v, 8'h00};
          2'd2: state_o.address = state_i.address | {4'h0, v, 4'h0};
          default: state_o.address = state_i.address | {8'h00, v};
        endcase
        if (state_i.digit == 2'd3) begin
          state_o.digit = 2'd0;
          state_o.phase = PH_TYPE;
        end else begin
          state_o.digit = state_i.digit + 2'd1;
        end
      end
      PH_TYPE: begin
        if (state_i.digit == 2'd0) begin
          state_o.digit = 2'd1;
        end else begin
          state_o.digit = 2'd0;
          state_o.index = '0;
          state_o.phase = (state_i.length == 8'd0) ? PH_SUM : PH_DATA;
        end
      end
      PH_DATA: begin
        if (state_i.digit == 2'd0) begin
          state_o.high = v[3:0];
          state_o.digit = 2'd1;
        end else begin
          if (byte_addr > state_i.max_addr) state_o.max_addr = byte_addr;
          if (state_i.total != '1) state_o.total = state_i.total + 32'd1;
          state_o.digit = 2'd0;
          state_o.index = next_index;
          if (next_index >= state_i.length) state_o.phase = PH_SUM;
          result_valid_o = 1'b1;
          result_o.byte_address = byte_addr;
          result_o.byte_value = {state_i.high, 4'h0} | v;
          result_o.bytes_so_far = state_o.total;
          result_o.highest_address = state_o.max_addr;
        end
      end
      PH_SUM: begin
        if (state_i.digit == 2'd0) begin
          state_o.digit = 2'd1;
        end else begin
          state_o.digit = 2'd0;
          state_o.phase = PH_WAIT;
        end
      end
      default: begin
        if (text_char_i == COLON_CHAR) begin
          state_o.phase = PH_LEN;
          state_o.digit = 2'd0;
          state_o.length = '0;
          state_o.address = '0;
          state_o.index = '0;
        end
      end
    endcase
  end

endmodule

// ===== rtl/core/ihex_obuf.sv =====
// Output register with one skid entry for decoded byte words.
`timescale 1ns / 1ps

module ihex_obuf (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  ihex_pkg::ihex_result_t data_i,
  output logic                   room_o,
  ihex_byte_if.source            out_o
);
  import ihex_pkg::*;

  logic         main_valid_q, main_valid_d;
  logic         skid_valid_q, skid_valid_d;
  ihex_result_t main_q, main_d;
  ihex_result_t skid_q, skid_d;
  logic         pop;

  assign room_o = !skid_valid_q;
  assign pop = main_valid_q && out_o.ready;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d = main_q;
    skid_d = skid_q;
    if (pop) begin
      main_valid_d = skid_valid_q;
      main_d = skid_q;
      skid_valid_d = 1'b0;
    end
    if (push_i) begin
      if (!main_valid_q || pop) begin
        main_valid_d = 1'b1;
        main_d = data_i;
      end else begin
        skid_valid_d = 1'b1;
        skid_d = data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign out_o.valid = main_valid_q;
  assign out_o.byte_address = main_q.byte_address;
  assign out_o.byte_value = main_q.byte_value;
  assign out_o.bytes_so_far = main_q.bytes_so_far;
  assign out_o.highest_address = main_q.highest_address;

endmodule

// ===== rtl/core/intel_hex_record_parser.sv =====
// Top level of the hex record parser: parse state registers, step logic, output buffer.
//
// Usage: in_i carries one text character per word. Characters up to ':' are
// dropped; after it the record fields are taken by position (length, address,
// type, data pairs, checksum). Each complete data digit pair yields one word
// on out_o with its address, value, running byte count and highest address.
// A byte word enters the output register, or the skid if that is full, when its
// second digit is taken. Throughput: one character per cycle while in_i.ready is
// high; all parsing is a single step of logic between state and output registers.
// The receiver may stall: a one-entry skid holds a second word, and in_i.ready
// drops only while both the output register and the skid are full.
// Reset: the parser waits for a colon, counts and the highest address clear,
// and no word is pending.
`timescale 1ns / 1ps

module intel_hex_record_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  ihex_char_if.sink   in_i,
  ihex_byte_if.source out_o
);
  import ihex_pkg::*;

  ihex_state_t  state_q, state_d;
  ihex_result_t result;
  logic         result_valid;
  logic         room;
  logic         accept;

  assign in_i.ready = room;
  assign accept = in_i.valid && room;

  ihex_step u_step (
    .state_i        (state_q),
    .text_char_i    (in_i.text_char),
    .state_o        (state_d),
    .result_o       (result),
    .result_valid_o (result_valid)
  );

  ihex_obuf u_obuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept && result_valid),
    .data_i (result),
    .room_o (room),
    .out_o  (out_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_WAIT, default: '0};
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  // skid full implies output register full
  assert property (@(posedge clk_i) disable iff (!rst_ni) !in_i.ready |-> out_o.valid)
    else $error("skid holds a word while output register is empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.highest_address >= out_o.byte_address)
    else $error("highest address below emitted address");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == PH_WAIT |-> state_q.digit == 2'd0)
    else $error("digit count nonzero while waiting for colon");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == PH_DATA |-> state_q.index < state_q.length)
    else $error("data index past record length");

endmodule
